### hw/rtl/mplct_pkg.sv
// ----------------------------------------------------------------------------
// mplct_pkg
// Types, codes and constants shared by the multi-mode timer block.
// ----------------------------------------------------------------------------
package mplct_pkg;

    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [COUNT_W-1:0] PRESET_RESET = 32'd1000;

    // blink slice of 200 ticks split as 8 * 25; x / 25 by reciprocal multiply
    localparam int unsigned BLINK_SLICE = 200;
    localparam int unsigned BLINK_PRE   = 3;
    localparam int unsigned BLINK_SHIFT = 35;
    localparam logic [31:0] BLINK_RECIP = 32'h51EB_851F;
    localparam int unsigned BLINK_X_W   = COUNT_W - BLINK_PRE;
    localparam int unsigned BLINK_P_W   = BLINK_X_W + 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PRESET = 2'd0,
        REG_MODE   = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        OP_STEP   = 1'b0,
        OP_RELOAD = 1'b1
    } timer_op_t;

    typedef enum logic [2:0] {
        MODE_TON           = 3'd0,
        MODE_TOF           = 3'd1,
        MODE_DELAY_ON      = 3'd2,
        MODE_PULSE         = 3'd3,
        MODE_REPEAT        = 3'd4,
        MODE_REPEAT_LOCKED = 3'd5,
        MODE_BLINK         = 3'd6,
        MODE_BLINK_LIMITED = 3'd7
    } timer_mode_t;

    typedef struct packed {
        logic [COUNT_W-1:0] remaining;
        logic               busy;
        logic               command;     // busy gate while blink_pend is set
        logic               prev_run;
        logic               blink_pend;  // command still to be derived from blink_a
        logic [COUNT_W-1:0] blink_a;
    } timer_state_t;

endpackage

### hw/rtl/mplct_if.sv
// ----------------------------------------------------------------------------
// mplct channel interfaces
// Valid/ready channels for step requests, results and register writes.
// ----------------------------------------------------------------------------
interface mplct_req_if;
    import mplct_pkg::*;
    logic               valid;
    logic               ready;
    logic               operation;
    logic               run;
    logic [COUNT_W-1:0] elapsed_ticks;

    modport source (output valid, output operation, output run, output elapsed_ticks,
                    input ready);
    modport sink   (input valid, input operation, input run, input elapsed_ticks,
                    output ready);
endinterface

interface mplct_rsp_if;
    import mplct_pkg::*;
    logic               valid;
    logic               ready;
    logic               command;
    logic               busy_res;
    logic [COUNT_W-1:0] remaining;

    modport source (output valid, output command, output busy_res, output remaining,
                    input ready);
    modport sink   (input valid, input command, input busy_res, input remaining,
                    output ready);
endinterface

interface mplct_cfg_if;
    import mplct_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/multi_mode_plc_timer_top.sv
// ----------------------------------------------------------------------------
// multi_mode_plc_timer_top
// Eight-mode programmable-logic timer (on/off delay, pulse, repeat, blink).
// ----------------------------------------------------------------------------
// Usage
//   req : one beat per timer step or reload (operation, run, elapsed_ticks)
//   rsp : one beat per request (command, busy_res, remaining)
//   cfg : register writes, index 0 preset_ticks, index 1 timer_mode; always
//         ready, write only while no request is outstanding
// Timing
//   a request updates the timer state at the edge it is accepted; its result
//   moves into the result register once that register is free or being
//   emptied, and rsp.valid rises with it. One request per cycle is sustained
//   while rsp.ready stays high: the state update is a single saturating
//   subtract and flag logic, and the limited-blink command bit comes from a
//   reciprocal multiply in the result stage.
// Stall
//   the state stage and result register form a two-deep pipeline; with both
//   full and rsp.ready low, req.ready drops and everything holds
// Reset
//   preset_ticks 1000, mode on-delay, count and flags cleared, no result
//   pending; req.ready is high out of reset
// ----------------------------------------------------------------------------
module multi_mode_plc_timer_top
    import mplct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mplct_req_if.sink    req,
    mplct_rsp_if.source  rsp,
    mplct_cfg_if.sink    cfg
);

    logic [COUNT_W-1:0] preset_reg;
    timer_mode_t        mode_reg;
    timer_state_t       st_reg;
    timer_state_t       st_next;
    logic               s1_valid_reg;
    logic               blink_bit_reg;
    logic               out_valid_reg;
    logic               out_cmd_reg;
    logic               out_busy_reg;
    logic [COUNT_W-1:0] out_rem_reg;

    logic                   req_acc;
    logic                   adv;
    logic                   cmd_eff;
    logic                   blink_bit;
    logic [BLINK_X_W-1:0]   blink_x;
    logic [BLINK_P_W-1:0]   blink_prod;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preset_reg <= PRESET_RESET;
            mode_reg   <= MODE_TON;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_PRESET: preset_reg <= cfg.data[COUNT_W-1:0];
                REG_MODE:   mode_reg   <= timer_mode_t'(cfg.data[2:0]);
                default:    ;
            endcase
        end
    end

    // floor(a / 200) = floor((a >> 3) * recip >> 35), bit 0 gives the phase
    assign blink_x    = st_reg.blink_a[COUNT_W-1:BLINK_PRE];
    assign blink_prod = BLINK_P_W'(blink_x) * BLINK_P_W'(BLINK_RECIP);
    assign blink_bit  = blink_prod[BLINK_SHIFT] & st_reg.command;

    // a pending blink command is resolved from the registered blink bit
    assign cmd_eff = st_reg.blink_pend ? blink_bit_reg : st_reg.command;

    assign adv       = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || !out_valid_reg || rsp.ready;
    assign req_acc   = req.valid && req.ready;

    mplct_step u_step (
        .cur           (st_reg),
        .cur_cmd       (cmd_eff),
        .preset        (preset_reg),
        .mode          (mode_reg),
        .operation     (req.operation),
        .run           (req.run),
        .elapsed_ticks (req.elapsed_ticks),
        .nxt           (st_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            blink_bit_reg <= 1'b0;
        end
        else
        begin
            blink_bit_reg <= blink_bit;
            if (req_acc)
            begin
                st_reg       <= st_next;
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_cmd_reg  <= st_reg.blink_pend ? blink_bit : st_reg.command;
            out_busy_reg <= st_reg.busy;
            out_rem_reg  <= st_reg.remaining;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.command   = out_cmd_reg;
    assign rsp.busy_res  = out_busy_reg;
    assign rsp.remaining = out_rem_reg;

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !rsp.ready |-> !req.ready)
        else $error("request taken with both stages full");

    a_reload_count: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req.operation == OP_RELOAD |=> st_reg.remaining == $past(preset_reg))
        else $error("reload did not load the preset");

    a_reload_flags: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req.operation == OP_RELOAD |=>
        st_reg.busy == $past(st_reg.busy) && st_reg.prev_run == $past(st_reg.prev_run))
        else $error("reload changed the timer flags");

    a_blink_pend: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req.operation == OP_STEP && mode_reg != MODE_BLINK_LIMITED
        |=> !st_reg.blink_pend)
        else $error("blink command left pending outside limited blink");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !req_acc |=> $stable(st_reg.remaining) && $stable(st_reg.busy))
        else $error("timer state moved without a request");

endmodule

### hw/rtl/mplct_step.sv
// ----------------------------------------------------------------------------
// mplct_step
// Next-state logic of the timer for one beat: load, saturating count-down
// and the mode-specific busy and command flags.
// ----------------------------------------------------------------------------
module mplct_step
    import mplct_pkg::*;
(
    input  timer_state_t       cur,
    input  logic               cur_cmd,
    input  logic [COUNT_W-1:0] preset,
    input  timer_mode_t        mode,
    input  logic               operation,
    input  logic               run,
    input  logic [COUNT_W-1:0] elapsed_ticks,
    output timer_state_t       nxt
);

    logic [COUNT_W-1:0] sub_raw;
    logic [COUNT_W-1:0] a1;
    logic [COUNT_W-1:0] a2;
    logic               load;
    logic               p_new;
    logic               c_new;
    logic               sub_en;
    logic               rise;

    // elapsed at or above the count drives it to zero
    assign sub_raw = (cur.remaining > elapsed_ticks) ? (cur.remaining - elapsed_ticks)
                                                     : '0;
    assign rise    = run & ~cur.prev_run;

    always_comb
    begin
        load   = 1'b0;
        a1     = cur.remaining;
        p_new  = cur.busy;
        sub_en = 1'b0;
        case (mode)
            MODE_TON:
            begin
                load  = run & ~cur.busy & ~cur_cmd;
                a1    = !run ? '0 : (load ? preset : cur.remaining);
                p_new = run && (a1 != '0);
            end
            MODE_TOF:
            begin
                load  = run;
                a1    = load ? preset : cur.remaining;
                p_new = !run && (a1 != '0);
            end
            MODE_DELAY_ON:
            begin
                load  = rise & ~cur.busy & ~cur_cmd;
                a1    = load ? preset : cur.remaining;
                p_new = !cur_cmd && (a1 != '0);
            end
            MODE_PULSE:
            begin
                load  = rise & ~cur.busy & ~cur_cmd;
                a1    = load ? preset : cur.remaining;
                p_new = (a1 != '0);
            end
            MODE_REPEAT:
            begin
                load  = run & ~cur.busy;
                a1    = !run ? '0 : (load ? preset : cur.remaining);
                p_new = run && (a1 != '0);
            end
            MODE_REPEAT_LOCKED, MODE_BLINK_LIMITED:
            begin
                load  = run & ~cur.busy;
                a1    = load ? preset : cur.remaining;
                p_new = (a1 != '0);
            end
            MODE_BLINK:
            begin
                load  = run & ~cur.busy;
                a1    = load ? preset : cur.remaining;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        // endless blink counts on the run level, every other mode on busy
        sub_en = (mode == MODE_BLINK) ? run : p_new;
        // a load zeroes this beat's elapsed time, so the preset passes through
        a2 = sub_en ? (load ? a1 : sub_raw) : a1;
        if (mode == MODE_BLINK)
        begin
            p_new = (a2 != '0) && run;
        end
    end

    always_comb
    begin
        c_new = cur_cmd;
        case (mode)
            MODE_TON:           c_new = run && (a2 == '0);
            MODE_TOF:           c_new = run || p_new;
            MODE_DELAY_ON:      c_new = p_new && (a2 == '0);
            MODE_PULSE:         c_new = (a2 != '0);
            MODE_REPEAT:        c_new = run && !cur.busy;
            MODE_REPEAT_LOCKED: c_new = run && !cur.busy;
            MODE_BLINK:         c_new = (a2 > (preset >> 1)) && p_new;
            MODE_BLINK_LIMITED: c_new = p_new;
            default:            c_new = cur_cmd;
        endcase
    end

    always_comb
    begin
        nxt = cur;
        if (operation == OP_RELOAD)
        begin
            nxt.remaining = preset;
        end
        else
        begin
            nxt.remaining  = a2;
            nxt.busy       = p_new;
            nxt.command    = c_new;
            nxt.blink_pend = (mode == MODE_BLINK_LIMITED);
            nxt.blink_a    = a2;
            if (mode == MODE_DELAY_ON || mode == MODE_PULSE)
            begin
                nxt.prev_run = run;
            end
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-mode timer: steps and reloads are sent
// over valid/ready with random gaps and result stalls, every accepted request
// is run through a cycle-free copy of the timer, and each result beat is
// compared with the oldest prediction. Preset and mode are rewritten between
// phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb;
    import mplct_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned IDLE_PCT    = 34;
    localparam int unsigned RAND_ITEMS  = 1600;
    localparam int unsigned MAX_PRINTED = 40;
    localparam int unsigned SETTLE      = 4;

    // register indexes outside the map, writes to them change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic               command;
        logic               busy;
        logic [COUNT_W-1:0] remaining;
    } timer_result_t;

    class timer_scoreboard;
        logic [COUNT_W-1:0] preset_ticks;
        timer_mode_t        mode;
        logic [COUNT_W-1:0] count;
        logic               busy;
        logic               command;
        logic               prev_run;
        timer_result_t      expected_q[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        reloads;
        int unsigned        writes;

        function new();
            preset_ticks = PRESET_RESET;
            mode         = MODE_TON;
            count        = '0;
            busy         = 1'b0;
            command      = 1'b0;
            prev_run     = 1'b0;
            errors       = 0;
            checked      = 0;
            reloads      = 0;
            writes       = 0;
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("tb: mismatch %s", msg);
        endtask

        function logic [COUNT_W-1:0] sat_sub(logic [COUNT_W-1:0] a, logic [COUNT_W-1:0] b);
            return (a > b) ? a - b : '0;
        endfunction

        function void apply_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            writes++;
            if (idx == REG_PRESET)
                preset_ticks = data;
            else if (idx == REG_MODE)
                mode = timer_mode_t'(data[2:0]);
        endfunction

        function void note_request(timer_op_t op, logic r, logic [COUNT_W-1:0] e);
            logic [COUNT_W-1:0] a;
            logic [COUNT_W-1:0] el;
            logic               p;
            logic               c;
            logic               rise;
            a  = count;
            p  = busy;
            c  = command;
            el = e;
            if (op == OP_RELOAD) begin
                a = preset_ticks;
                reloads++;
            end
            else begin
                case (mode)
                    MODE_TON:
                    begin
                        if (r && !p && !c)
                        begin
                            a  = preset_ticks;
                            el = '0;
                        end
                        if (!r)
                            a = '0;
                        p = r && a != 0;
                        if (p)
                            a = sat_sub(a, el);
                        c = r && a == 0;
                    end
                    MODE_TOF:
                    begin
                        if (r)
                        begin
                            a  = preset_ticks;
                            el = '0;
                        end
                        p = !r && a != 0;
                        if (p)
                            a = sat_sub(a, el);
                        c = r || p;
                    end
                    MODE_DELAY_ON:
                    begin
                        rise     = r && !prev_run;
                        prev_run = r;
                        if (rise && !p && !c)
                        begin
                            a  = preset_ticks;
                            el = '0;
                        end
                        p = !c && a != 0;
                        if (p)
                            a = sat_sub(a, el);
                        c = p && a == 0;
                    end
                    MODE_PULSE:
                    begin
                        rise     = r && !prev_run;
                        prev_run = r;
                        if (rise && !p && !c)
                        begin
                            a  = preset_ticks;
                            el = '0;
                        end
                        p = a != 0;
                        if (p)
                            a = sat_sub(a, el);
                        c = a != 0;
                    end
                    MODE_REPEAT:
                    begin
                        c = r && !p;
                        if (r && !p)
                        begin
                            a  = preset_ticks;
                            el = '0;
                        end
                        if (!r)
                            a = '0;
                        p = r && a != 0;
                        if (p)
                            a = sat_sub(a, el);
                    end
                    MODE_REPEAT_LOCKED:
                    begin
                        c = r && !p;
                        if (r && !p)
                        begin
                            a  = preset_ticks;
                            el = '0;
                        end
                        p = a != 0;
                        if (p)
                            a = sat_sub(a, el);
                    end
                    MODE_BLINK:
                    begin
                        if (r && !p)
                        begin
                            a  = preset_ticks;
                            el = '0;
                        end
                        if (r)
                            a = sat_sub(a, el);
                        p = a != 0 && r;
                        c = (a > preset_ticks / 2) && p;
                    end
                    default:
                    begin
                        if (r && !p)
                        begin
                            a  = preset_ticks;
                            el = '0;
                        end
                        p = a != 0;
                        if (p)
                            a = sat_sub(a, el);
                        c = ((a / BLINK_SLICE) % 2 != 0) && p;
                    end
                endcase
            end
            count   = a;
            busy    = p;
            command = c;
            expected_q.push_back('{command: c, busy: p, remaining: a});
        endfunction

        task check_result(logic cmd_got, logic busy_got, logic [COUNT_W-1:0] rem_got);
            timer_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result beat: command %0b busy %0b remaining %0d",
                                 cmd_got, busy_got, rem_got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (cmd_got !== want.command)
                report($sformatf("beat %0d command got %0b want %0b",
                                 checked, cmd_got, want.command));
            if (busy_got !== want.busy)
                report($sformatf("beat %0d busy_res got %0b want %0b",
                                 checked, busy_got, want.busy));
            if (rem_got !== want.remaining)
                report($sformatf("beat %0d remaining got %0d want %0d",
                                 checked, rem_got, want.remaining));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        quiet;
    int unsigned cycle_count = 0;
    int unsigned phases_run;

    timer_scoreboard sb = new();

    mplct_req_if req_ch();
    mplct_rsp_if rsp_ch();
    mplct_cfg_if cfg_ch();

    multi_mode_plc_timer_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // accepted beats on all three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.apply_write(cfg_ch.index, cfg_ch.data);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(timer_op_t'(req_ch.operation), req_ch.run,
                                req_ch.elapsed_ticks);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.command, rsp_ch.busy_res, rsp_ch.remaining);
        end
    end

    task automatic send_beat(input timer_op_t op, input logic r, input logic [COUNT_W-1:0] e);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.run <= r;
        req_ch.elapsed_ticks <= e;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [COUNT_W-1:0] pick_elapsed(logic [COUNT_W-1:0] preset_val);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return '0;
        if (sel < 14)
            return $urandom();
        if (sel < 17)
            return '1;
        return $urandom_range(0, preset_val / 3 + 8);
    endfunction

    function automatic logic [COUNT_W-1:0] pick_preset(int unsigned phase);
        int unsigned sel;
        if (phase == 0)
            return '0;
        if (phase == 1)
            return '1;
        sel = $urandom_range(0, 99);
        if (sel < 6)
            return '0;
        if (sel < 10)
            return 32'd1;
        if (sel < 16)
            return $urandom();
        if (sel < 20)
            return '1;
        if (sel < 40)
            return $urandom_range(200, 700);
        return $urandom_range(20, 3000);
    endfunction

    initial
    begin : stimulus
        timer_mode_t        mode_val;
        logic [COUNT_W-1:0] preset_val;
        logic [CFG_DATA_W-1:0] mode_data;
        logic               run_level;
        int unsigned        sent;
        int unsigned        phase_len;
        int unsigned        sel;
        int unsigned        guard;
        int                 hold;

        rst_n <= 1'b0;
        quiet <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.operation <= OP_STEP;
        req_ch.run <= 1'b0;
        req_ch.elapsed_ticks <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_PRESET;
        cfg_ch.data <= '0;
        phases_run = 0;
        sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: on-delay with a preset of 1000
        send_beat(OP_STEP, 1'b1, '0);
        send_beat(OP_STEP, 1'b1, 32'd999);
        send_beat(OP_STEP, 1'b1, '1);
        send_beat(OP_RELOAD, 1'b0, '1);
        send_beat(OP_STEP, 1'b0, 32'd5);
        drain_results();
        write_reg(REG_PRESET, 32'd450);
        for (int m = 1; m < 8; m++)
        begin
            drain_results();
            write_reg(REG_MODE, CFG_DATA_W'(m));
            send_beat(OP_STEP, 1'b1, 32'd30);
            send_beat(OP_STEP, 1'b0, 32'd250);
            send_beat(OP_STEP, 1'b1, '1);
        end

        run_level = 1'b0;
        hold = 0;
        while (sent < RAND_ITEMS)
        begin
            drain_results();
            preset_val = pick_preset(phases_run);
            mode_val = (phases_run < 8) ? timer_mode_t'(phases_run[2:0])
                                        : timer_mode_t'($urandom_range(0, 7));
            // upper data bits of the mode write are don't-care
            mode_data = CFG_DATA_W'(mode_val);
            if ($urandom_range(0, 1))
                mode_data = ($urandom() & ~32'h7) | mode_data;
            if (phases_run == 2)
            begin
                write_reg(REG_SPARE_LO, $urandom());
                write_reg(REG_SPARE_HI, $urandom());
            end
            write_reg(REG_PRESET, preset_val);
            write_reg(REG_MODE, mode_data);
            quiet <= (phases_run == 5 || phases_run == 6);
            phase_len = $urandom_range(40, 120);
            for (int i = 0; i < phase_len && sent < RAND_ITEMS; i++)
            begin
                if (hold <= 0)
                begin
                    run_level = ~run_level;
                    hold = $urandom_range(1, 12);
                end
                hold--;
                sel = $urandom_range(0, 99);
                if (sel < 5)
                    send_beat(OP_RELOAD, 1'($urandom_range(0, 1)), $urandom());
                else if (sel < 10)
                    send_beat(OP_STEP, 1'($urandom_range(0, 1)), pick_elapsed(preset_val));
                else
                    send_beat(OP_STEP, run_level, pick_elapsed(preset_val));
                sent++;
                // hold the sender until the pipeline has emptied, state kept
                if (phases_run == 3 && i == phase_len / 2)
                    drain_results();
            end
            phases_run++;
        end

        quiet <= 1'b0;
        req_ch.valid <= 1'b0;
        guard = 0;
        while (sb.outstanding() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.outstanding()));

        $display("tb: %0d result beats checked, %0d of them reloads, all eight modes",
                 sb.checked, sb.reloads);
        $display("tb: %0d register writes over %0d random phases, presets from 0 to all ones",
                 sb.writes, phases_run);
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: errors");
        $finish;
    end

endmodule
